[sv/fnvw_pkg.sv]
`timescale 1ns / 1ps
// fnvw_pkg: shared constants and the fnv prime multiply for the word fingerprint block
// depends on nothing; imported by every module of the block

package fnvw_pkg;

    localparam int FNV_MAX_WORD_BYTES = 8;
    localparam int WORD_FIELD_W       = 64;
    localparam int BYTE_COUNT_W       = 4;
    localparam int S_TDATA_W          = 72;
    localparam int FINGERPRINT_W      = 64;

    localparam logic [63:0] FNV_OFFSET_BASIS = 64'hcbf2_9ce4_8422_2325;

    // prime is 2^40 + 2^8 + 0xb3, so the product mod 2^64 is a sum of shifts
    function automatic logic [63:0] fnv_mult(input logic [63:0] h);
        logic [63:0] p;
        p = (h << 40) + (h << 8) + (h << 7) + (h << 5) + (h << 4) + (h << 1) + h;
        return p;
    endfunction

endpackage

[sv/fnvw_front.sv]
`timescale 1ns / 1ps
// fnvw_front: input side, clamps the byte count and packs the queue entry
// depends on fnvw_pkg

module fnvw_front import fnvw_pkg::*; #(
    parameter int MAX_WORD_BYTES = FNV_MAX_WORD_BYTES,
    parameter int WORD_W         = MAX_WORD_BYTES * 8,
    parameter int CNT_W          = $clog2(MAX_WORD_BYTES + 1),
    parameter int ENTRY_W        = WORD_W + CNT_W + 1
) (
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic                 s_tlast,
    output logic                 push,
    output logic [ENTRY_W-1:0]   push_data,
    input  logic                 q_full
);

    logic [BYTE_COUNT_W-1:0] byte_count;
    logic [CNT_W-1:0]        count_sat;

    assign byte_count = s_tdata[WORD_FIELD_W +: BYTE_COUNT_W];

    // counts beyond the word size saturate
    always_comb begin
        if (byte_count > BYTE_COUNT_W'(MAX_WORD_BYTES)) begin
            count_sat = CNT_W'(MAX_WORD_BYTES);
        end else begin
            count_sat = CNT_W'(byte_count);
        end
    end

    assign s_tready  = !q_full;
    assign push      = s_tvalid && !q_full;
    assign push_data = {s_tlast, count_sat, s_tdata[WORD_W-1:0]};

endmodule

[sv/fnvw_queue.sv]
`timescale 1ns / 1ps
// fnvw_queue: two-entry fifo between the front and the absorber
// depends on fnvw_pkg

module fnvw_queue import fnvw_pkg::*; #(
    parameter int DATA_W = WORD_FIELD_W
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  logic [DATA_W-1:0] push_data,
    output logic              full,
    input  logic              pop,
    output logic              q_valid,
    output logic [DATA_W-1:0] q_data
);

    logic [DATA_W-1:0] mem [2];
    logic              wr_ptr_reg, wr_ptr_next;
    logic              rd_ptr_reg, rd_ptr_next;
    logic [1:0]        count_reg,  count_next;

    assign full    = (count_reg == 2'd2);
    assign q_valid = (count_reg != 2'd0);
    assign q_data  = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

[sv/fnvw_back.sv]
`timescale 1ns / 1ps
// fnvw_back: byte-serial fnv-1a absorber with the output register
// depends on fnvw_pkg

module fnvw_back import fnvw_pkg::*; #(
    parameter int MAX_WORD_BYTES = FNV_MAX_WORD_BYTES,
    parameter int WORD_W         = MAX_WORD_BYTES * 8,
    parameter int CNT_W          = $clog2(MAX_WORD_BYTES + 1),
    parameter int ENTRY_W        = WORD_W + CNT_W + 1
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     q_valid,
    input  logic [ENTRY_W-1:0]       q_data,
    output logic                     pop,
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [FINGERPRINT_W-1:0] m_tdata
);

    logic [63:0]              hash_reg, hash_next;
    logic [WORD_W-1:0]        word_reg, word_next;
    logic [CNT_W-1:0]         cnt_reg,  cnt_next;
    logic                     last_reg, last_next;
    logic                     busy_reg, busy_next;
    logic                     m_valid_reg, m_valid_next;
    logic [FINGERPRINT_W-1:0] m_data_reg,  m_data_next;

    logic absorb;
    logic finish;
    logic out_free;
    logic take;

    assign out_free = !m_valid_reg || m_tready;
    assign absorb   = busy_reg && (cnt_reg != '0);
    // a last item waits here until the output register is free
    assign finish   = busy_reg && (cnt_reg == '0) && (!last_reg || out_free);
    assign take     = q_valid && (!busy_reg || finish);
    assign pop      = take;

    always_comb begin
        hash_next    = hash_reg;
        word_next    = word_reg;
        cnt_next     = cnt_reg;
        last_next    = last_reg;
        busy_next    = busy_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;

        if (m_tready) begin
            m_valid_next = 1'b0;
        end

        if (absorb) begin
            hash_next = fnv_mult(hash_reg ^ {56'd0, word_reg[7:0]});
            word_next = word_reg >> 8;
            cnt_next  = cnt_reg - CNT_W'(1);
        end

        if (finish) begin
            busy_next = 1'b0;
            if (last_reg) begin
                m_valid_next = 1'b1;
                m_data_next  = (hash_reg == 64'd0) ? 64'd1 : hash_reg;
                hash_next    = FNV_OFFSET_BASIS;
            end
        end

        if (take) begin
            word_next = q_data[WORD_W-1:0];
            cnt_next  = q_data[WORD_W +: CNT_W];
            last_next = q_data[ENTRY_W-1];
            busy_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        word_reg   <= word_next;
        last_reg   <= last_next;
        m_data_reg <= m_data_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hash_reg    <= FNV_OFFSET_BASIS;
            cnt_reg     <= '0;
            busy_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            hash_reg    <= hash_next;
            cnt_reg     <= cnt_next;
            busy_reg    <= busy_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    a_no_zero_out: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_data_reg != '0))
        else $error("fingerprint of zero presented");

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(MAX_WORD_BYTES))
        else $error("byte counter beyond word size");

    a_idle_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        !busy_reg |-> (cnt_reg == '0))
        else $error("idle absorber with bytes pending");

    a_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        (finish && last_reg) |=> (hash_reg == FNV_OFFSET_BASIS))
        else $error("hash not restarted after message end");

endmodule

[sv/fnv1a_word_fingerprint.sv]
`timescale 1ns / 1ps
// fnv1a_word_fingerprint: top level of the streaming 64-bit fnv-1a fingerprint engine
// depends on fnvw_pkg, fnvw_front, fnvw_queue, fnvw_back

// Streaming 64-bit FNV-1a fingerprint. Each input transaction carries a word and a byte
// count; the low bytes of the word are absorbed least significant first, each xored into
// the running hash which is then multiplied by the FNV prime modulo 2^64. Counts above
// the word size saturate, a count of zero absorbs nothing. A transaction with s_tlast
// set produces one output transaction holding the hash (zero shows as one) and the hash
// restarts from the offset basis. The absorber takes an item's bytes one byte per cycle
// through the shift-add prime multiply, then retires the item, overlapped with loading
// the next; an item with s_tlast set is retired only once the output register is free.
// A two-entry queue lets the input keep accepting while the absorber works, until the
// queue fills, and the output register holds a fingerprint while m_tready is low.

module fnv1a_word_fingerprint import fnvw_pkg::*; #(
    parameter int MAX_WORD_BYTES = FNV_MAX_WORD_BYTES
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [S_TDATA_W-1:0]     s_tdata,   // word[63:0], byte_count[67:64], zero[71:68]
    input  logic                     s_tlast,
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [FINGERPRINT_W-1:0] m_tdata    // fingerprint[63:0]
);

    localparam int WORD_W  = MAX_WORD_BYTES * 8;
    localparam int CNT_W   = $clog2(MAX_WORD_BYTES + 1);
    localparam int ENTRY_W = WORD_W + CNT_W + 1;

    // queue entry: {last, saturated count, word}
    logic               push;
    logic [ENTRY_W-1:0] push_data;
    logic               q_full;
    logic               q_valid;
    logic [ENTRY_W-1:0] q_data;
    logic               pop;

    fnvw_front #(
        .MAX_WORD_BYTES (MAX_WORD_BYTES),
        .WORD_W         (WORD_W),
        .CNT_W          (CNT_W),
        .ENTRY_W        (ENTRY_W)
    ) u_front (
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .push      (push),
        .push_data (push_data),
        .q_full    (q_full)
    );

    // decouples input acceptance from the byte-serial absorber
    fnvw_queue #(
        .DATA_W (ENTRY_W)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (pop),
        .q_valid   (q_valid),
        .q_data    (q_data)
    );

    fnvw_back #(
        .MAX_WORD_BYTES (MAX_WORD_BYTES),
        .WORD_W         (WORD_W),
        .CNT_W          (CNT_W),
        .ENTRY_W        (ENTRY_W)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_data   (q_data),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
